// ===== design/hcf_pkg.sv =====
// hcf_pkg: shared constants, types and sequencer states of the heading filter
// used by every design file but hcf_ifs through scoped names
`default_nettype none

package hcf_pkg;

    localparam int TURN_UNITS     = 46080;
    localparam int WINDOW_LEN_DEF = 5;
    localparam int ANGLE_W        = 16;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;
    localparam int MUL_W          = 33;
    localparam int PROD_W         = 2 * MUL_W;

    localparam logic [ANGLE_W-1:0] TURN_LIMIT   = 16'd46080;
    localparam logic [ANGLE_W-1:0] WEIGHT_RESET = 16'd64225;

    // 512 turns, lifts any intermediate angle above zero
    localparam logic [26:0] WRAP_BIAS = 27'd23592960;

    // floor(t / 45) = (t * RECIP45) >> 22 exact for t below 2^16
    localparam logic [MUL_W-1:0] RECIP45  = 33'd93207;
    // floor(2^38 / 125), estimate low by at most one
    localparam logic [MUL_W-1:0] RECIP125 = 33'd2199023255;

    localparam logic [35:0] MS_HALF = 36'd500;
    localparam logic [31:0] MS_DIV8 = 32'd125;

    localparam logic REG_OFFSET = 1'b0;
    localparam logic REG_WEIGHT = 1'b1;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_offset;
        logic [ANGLE_W-1:0] gyro_weight;
    } hcf_cfg_t;

    typedef struct packed {
        logic               en;
        logic [ANGLE_W-1:0] data;
    } hcf_win_wr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS_MUL,
        ST_ABS_FIX,
        ST_RATE_MUL,
        ST_DIV_PREP,
        ST_DIV_MUL,
        ST_DIV_FIX,
        ST_GYRO_SUM,
        ST_GYRO_MUL,
        ST_GYRO_FIX,
        ST_BLEND_MUL,
        ST_BLEND_FIX,
        ST_STORE,
        ST_MEAN_MUL,
        ST_MEAN_FIX
    } hcf_state_t;

endpackage

`default_nettype wire

// ===== design/hcf_ifs.sv =====
// hcf_in_if, hcf_out_if: valid/ready item channels of the heading filter
// depends on nothing
`default_nettype none

interface hcf_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] raw_angle;
    logic signed [18:0] yaw_rate;
    logic        [15:0] elapsed_ms;

    modport source (output valid, output raw_angle, output yaw_rate, output elapsed_ms,
                    input ready);
    modport sink   (input valid, input raw_angle, input yaw_rate, input elapsed_ms,
                    output ready);
endinterface

interface hcf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

`default_nettype wire

// ===== design/heading_complementary_filter_top.sv =====
// heading_complementary_filter_top: sequencer and datapath of the heading filter
// depends on hcf_pkg, hcf_ifs, hcf_mul, hcf_regs, hcf_window
//
// usage
//   in_ch carries one sample item (raw_angle, yaw_rate, elapsed_ms); out_ch
//   returns one heading item per sample, in order.
//   the apb port holds angle_offset (0x0) and gyro_weight (0x4); write it
//   only while no item is in flight.
//   each item runs through 14 sequencer steps on one shared 33x33 multiplier:
//   wrap of the absolute angle, rate times time, divide by 1000, wrap of the
//   gyro heading, blend, window update and mean. the heading register is
//   loaded as the sequencer leaves its last step, and in_ch.ready is high
//   only in the idle step, so a new item is not taken while one is in flight.
//   the result sits in an output register; the next item is accepted while it
//   waits, and the sequencer holds in its last step while out_ch stalls with
//   a result still pending.
//   reset clears gyro heading, window entries, write position and the output
//   valid; gyro_weight returns to 64225 and angle_offset to 0.
`default_nettype none

module heading_complementary_filter_top #(
    parameter int WINDOW_LEN = hcf_pkg::WINDOW_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    hcf_in_if.sink                     in_ch,
    hcf_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hcf_pkg::ADDR_W-1:0] paddr,
    input  logic [hcf_pkg::DATA_W-1:0] pwdata,
    output logic [hcf_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int SUM_W = $clog2(WINDOW_LEN * (hcf_pkg::TURN_UNITS - 1) + 1);
    localparam int MUL_W = hcf_pkg::MUL_W;
    localparam logic [MUL_W-1:0] MEAN_RECIP = MUL_W'((64'd1 << 31) / WINDOW_LEN);
    localparam logic [SUM_W:0]   MEAN_HALF  = (SUM_W + 1)'(WINDOW_LEN / 2);
    localparam logic [SUM_W:0]   MEAN_DIV   = (SUM_W + 1)'(WINDOW_LEN);
    localparam logic [SUM_W-1:0] SUM_LIMIT  =
        SUM_W'(WINDOW_LEN * (hcf_pkg::TURN_UNITS - 1));

    hcf_pkg::hcf_state_t  state_reg;
    hcf_pkg::hcf_state_t  state_next;
    hcf_pkg::hcf_cfg_t    cfg;
    hcf_pkg::hcf_win_wr_t win_wr;

    logic signed [MUL_W-1:0]          op_a;
    logic signed [MUL_W-1:0]          op_b;
    logic signed [hcf_pkg::PROD_W-1:0] product;
    logic [SUM_W-1:0]                 win_sum;

    logic signed [18:0] rate_reg;
    logic [15:0]        ms_reg;
    logic [25:0]        wrap_u_reg;
    logic [25:0]        wrap_u_next;
    logic [15:0]        abs_reg;
    logic [15:0]        acc_reg;
    logic [30:0]        y_reg;
    logic               neg_reg;
    logic [24:0]        quo_reg;
    logic [15:0]        blend_reg;
    logic [15:0]        heading_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_load;

    logic [25:0] u_abs;
    logic [15:0] wrap_t;
    logic [10:0] wrap_q;
    logic [15:0] wrap_rem;
    logic [15:0] wrapped;
    logic [35:0] p_mag;
    logic [35:0] y_full;
    logic [24:0] div_q0;
    logic [31:0] div_rem;
    logic [24:0] div_q;
    logic [26:0] quo_signed;
    logic [26:0] u_gyro;
    logic [16:0] blend_diff;
    logic [33:0] blend_sum;
    logic [SUM_W:0] mean_in;
    logic [15:0]    mean_q0;
    logic [SUM_W:0] mean_rem;
    logic [15:0]    mean_q;

    hcf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hcf_mul u_mul (
        .clk     (clk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    hcf_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (win_wr),
        .sum   (win_sum)
    );

    // datapath arithmetic
    always_comb
    begin
        u_abs = {{2{in_ch.raw_angle[23]}}, in_ch.raw_angle}
              - {10'd0, cfg.angle_offset} + hcf_pkg::WRAP_BIAS[25:0];

        // mod one turn: low 10 bits pass, upper part mod 45
        wrap_t   = wrap_u_reg[25:10];
        wrap_q   = product[32:22];
        wrap_rem = wrap_t - 16'({5'd0, wrap_q} * 16'd45);
        wrapped  = {wrap_rem[5:0], wrap_u_reg[9:0]};

        p_mag  = product[35] ? (36'd0 - product[35:0]) : product[35:0];
        y_full = p_mag + hcf_pkg::MS_HALF;

        div_q0  = product[62:38];
        div_rem = {1'b0, y_reg} - 32'({7'd0, div_q0} * hcf_pkg::MS_DIV8);
        div_q   = (div_rem >= hcf_pkg::MS_DIV8) ? div_q0 + 25'd1 : div_q0;

        quo_signed = neg_reg ? (27'd0 - {2'd0, quo_reg}) : {2'd0, quo_reg};
        u_gyro     = {11'd0, acc_reg} + hcf_pkg::WRAP_BIAS + quo_signed;

        blend_diff = {1'b0, acc_reg} - {1'b0, abs_reg};
        blend_sum  = {2'b00, abs_reg, 16'd0} + product[33:0] + 34'd32768;

        mean_in  = {1'b0, win_sum} + MEAN_HALF;
        mean_q0  = product[46:31];
        mean_rem = mean_in - (SUM_W + 1)'({16'd0, mean_q0} * 32'(WINDOW_LEN));
        mean_q   = (mean_rem >= MEAN_DIV) ? mean_q0 + 16'd1 : mean_q0;
    end

    // shared multiplier operands
    always_comb
    begin
        unique case (state_reg)
            hcf_pkg::ST_ABS_MUL, hcf_pkg::ST_GYRO_MUL:
            begin
                op_a = {17'd0, wrap_t};
                op_b = hcf_pkg::RECIP45;
            end
            hcf_pkg::ST_RATE_MUL:
            begin
                op_a = {{14{rate_reg[18]}}, rate_reg};
                op_b = {17'd0, ms_reg};
            end
            hcf_pkg::ST_DIV_MUL:
            begin
                op_a = {2'd0, y_reg};
                op_b = hcf_pkg::RECIP125;
            end
            hcf_pkg::ST_BLEND_MUL:
            begin
                op_a = {17'd0, cfg.gyro_weight};
                op_b = {{16{blend_diff[16]}}, blend_diff};
            end
            // kept in the last step so the product holds while out_ch stalls
            hcf_pkg::ST_MEAN_MUL, hcf_pkg::ST_MEAN_FIX:
            begin
                op_a = {{(MUL_W - SUM_W - 1){1'b0}}, mean_in};
                op_b = MEAN_RECIP;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        wrap_u_next = wrap_u_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            hcf_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next  = hcf_pkg::ST_ABS_MUL;
                    wrap_u_next = u_abs;
                end
            end
            hcf_pkg::ST_ABS_MUL:   state_next = hcf_pkg::ST_ABS_FIX;
            hcf_pkg::ST_ABS_FIX:   state_next = hcf_pkg::ST_RATE_MUL;
            hcf_pkg::ST_RATE_MUL:  state_next = hcf_pkg::ST_DIV_PREP;
            hcf_pkg::ST_DIV_PREP:  state_next = hcf_pkg::ST_DIV_MUL;
            hcf_pkg::ST_DIV_MUL:   state_next = hcf_pkg::ST_DIV_FIX;
            hcf_pkg::ST_DIV_FIX:   state_next = hcf_pkg::ST_GYRO_SUM;
            hcf_pkg::ST_GYRO_SUM:
            begin
                state_next  = hcf_pkg::ST_GYRO_MUL;
                wrap_u_next = u_gyro[25:0];
            end
            hcf_pkg::ST_GYRO_MUL:  state_next = hcf_pkg::ST_GYRO_FIX;
            hcf_pkg::ST_GYRO_FIX:  state_next = hcf_pkg::ST_BLEND_MUL;
            hcf_pkg::ST_BLEND_MUL: state_next = hcf_pkg::ST_BLEND_FIX;
            hcf_pkg::ST_BLEND_FIX: state_next = hcf_pkg::ST_STORE;
            hcf_pkg::ST_STORE:     state_next = hcf_pkg::ST_MEAN_MUL;
            hcf_pkg::ST_MEAN_MUL:  state_next = hcf_pkg::ST_MEAN_FIX;
            hcf_pkg::ST_MEAN_FIX:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = hcf_pkg::ST_IDLE;
                end
            end
            default:               state_next = hcf_pkg::ST_IDLE;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && !out_ch.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcf_pkg::ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == hcf_pkg::ST_GYRO_FIX)
                acc_reg <= wrapped;
        end
    end

    always_ff @(posedge clk)
    begin
        wrap_u_reg <= wrap_u_next;
        if (state_reg == hcf_pkg::ST_IDLE && in_ch.valid)
        begin
            rate_reg <= in_ch.yaw_rate;
            ms_reg   <= in_ch.elapsed_ms;
        end
        if (state_reg == hcf_pkg::ST_ABS_FIX)
            abs_reg <= wrapped;
        if (state_reg == hcf_pkg::ST_DIV_PREP)
        begin
            y_reg   <= y_full[33:3];
            neg_reg <= product[35];
        end
        if (state_reg == hcf_pkg::ST_DIV_FIX)
            quo_reg <= div_q;
        if (state_reg == hcf_pkg::ST_BLEND_FIX)
            blend_reg <= blend_sum[31:16];
        if (out_load)
            heading_reg <= mean_q;
    end

    assign win_wr.en   = (state_reg == hcf_pkg::ST_STORE);
    assign win_wr.data = blend_reg;

    assign in_ch.ready    = (state_reg == hcf_pkg::ST_IDLE);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.heading = heading_reg;

`ifndef SYNTH
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg < hcf_pkg::TURN_LIMIT)
        else $error("gyro heading left one turn");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> state_reg == hcf_pkg::ST_ABS_MUL)
        else $error("accepted item did not start the sequence");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.heading < hcf_pkg::TURN_LIMIT)
        else $error("heading out of range");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        win_sum <= SUM_LIMIT)
        else $error("window sum exceeds its bound");
`endif

endmodule

`default_nettype wire

// ===== design/hcf_mul.sv =====
// hcf_mul: shared signed multiplier with registered product
// depends on hcf_pkg
`default_nettype none

module hcf_mul (
    input  logic                                clk,
    input  logic signed [hcf_pkg::MUL_W-1:0]    op_a,
    input  logic signed [hcf_pkg::MUL_W-1:0]    op_b,
    output logic signed [hcf_pkg::PROD_W-1:0]   product
);

    logic signed [hcf_pkg::PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// ===== design/hcf_regs.sv =====
// hcf_regs: apb configuration registers (offset, gyro weight)
// depends on hcf_pkg
`default_nettype none

module hcf_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcf_pkg::ADDR_W-1:0]     paddr,
    input  logic [hcf_pkg::DATA_W-1:0]     pwdata,
    output logic [hcf_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    output hcf_pkg::hcf_cfg_t              cfg
);

    hcf_pkg::hcf_cfg_t cfg_reg;
    hcf_pkg::hcf_cfg_t cfg_next;
    logic              reg_sel;

    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                hcf_pkg::REG_OFFSET: cfg_next.angle_offset = pwdata[15:0];
                hcf_pkg::REG_WEIGHT: cfg_next.gyro_weight  = pwdata[15:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_offset <= '0;
            cfg_reg.gyro_weight  <= hcf_pkg::WEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            hcf_pkg::REG_OFFSET: prdata = {16'd0, cfg_reg.angle_offset};
            hcf_pkg::REG_WEIGHT: prdata = {16'd0, cfg_reg.gyro_weight};
            default:             prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/hcf_window.sv =====
// hcf_window: ring of blended headings with a running sum of its entries
// depends on hcf_pkg
`default_nettype none

module hcf_window #(
    parameter int WINDOW_LEN = hcf_pkg::WINDOW_LEN_DEF
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  hcf_pkg::hcf_win_wr_t                                    wr,
    output logic [$clog2(WINDOW_LEN*(hcf_pkg::TURN_UNITS-1)+1)-1:0] sum
);

    localparam int SUM_W = $clog2(WINDOW_LEN * (hcf_pkg::TURN_UNITS - 1) + 1);
    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    logic [hcf_pkg::ANGLE_W-1:0] win_reg [WINDOW_LEN];
    logic [PTR_W-1:0]            pos_reg;
    logic [PTR_W-1:0]            pos_next;
    logic [SUM_W-1:0]            sum_reg;
    logic [SUM_W-1:0]            sum_next;

    always_comb
    begin
        sum_next = sum_reg - SUM_W'(win_reg[pos_reg]) + SUM_W'(wr.data);
        if (pos_reg == PTR_W'(WINDOW_LEN - 1))
            pos_next = '0;
        else
            pos_next = pos_reg + PTR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
                win_reg[i] <= '0;
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else if (wr.en)
        begin
            win_reg[pos_reg] <= wr.data;
            pos_reg          <= pos_next;
            sum_reg          <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire
